// ----- design/assert_macros.svh -----
// Assertion macros used by the bounding box RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is held
`define GVBB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check an implication on every rising edge, off while reset is held
`define GVBB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the next cycle, off while reset is held
`define GVBB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/gvbb_pkg.sv -----
// Types and constants of the grid value bounding box
`default_nettype none
package gvbb_pkg;

	localparam int MAX_DIM_DEF   = 4096;
	localparam int COMP_BITS_DEF = 16;
	localparam int COMP_W        = 16;
	localparam int BOX_W         = 12;
	localparam int DIM_REG_W     = 13;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam logic [DIM_REG_W-1:0] DIM_RESET = 13'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EMPTY_X     = 3'd0,
		CFG_EMPTY_Y     = 3'd1,
		CFG_EMPTY_Z     = 3'd2,
		CFG_GRID_WIDTH  = 3'd3,
		CFG_GRID_HEIGHT = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] cell_x;
		logic signed [COMP_W-1:0] cell_y;
		logic signed [COMP_W-1:0] cell_z;
	} cell_t;

	typedef struct packed {
		logic                     consumed;
		logic                     frame_done;
		logic                     found;
		logic [BOX_W-1:0]         left_col;
		logic [BOX_W-1:0]         top_row;
		logic [BOX_W-1:0]         right_col;
		logic [BOX_W-1:0]         bottom_row;
		logic signed [COMP_W-1:0] picked_x;
		logic signed [COMP_W-1:0] picked_y;
		logic signed [COMP_W-1:0] picked_z;
	} result_t;

endpackage
`default_nettype wire

// ----- design/grid_value_bounding_box.sv -----
// Top level of the grid value bounding box
//
//  channel | signals                                  | carries
//  --------+------------------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data              | one cell, row-major order
//  out     | out_valid, out_ready, out_data           | one result beat per cell
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes, always ready
//
// One cell per cycle sustained while out_ready stays high; each cell passes the input
// register and then the result register, which loads when the core takes the cell.
// While a finished result waits for out_ready the input register takes one more beat,
// then in_ready drops; in_ready follows out_ready combinationally.
// The compare and min/max logic between them sets the single-cycle path.
// Reset clears the scan state and loads the register defaults; no clearing pass.
`default_nettype none
module grid_value_bounding_box #(
	parameter int MAX_DIM   = gvbb_pkg::MAX_DIM_DEF,
	parameter int COMP_BITS = gvbb_pkg::COMP_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire gvbb_pkg::cell_t                 in_data,
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      gvbb_pkg::result_t               out_data,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [gvbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gvbb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gvbb_pkg::*;

	localparam int POS_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

	cell_t            empty;
	logic [POS_W-1:0] col_last, row_last;
	logic             take, valid_s1;
	cell_t            data_s1;

	gvbb_cfg #(
		.MAX_DIM(MAX_DIM),
		.POS_W  (POS_W)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.empty    (empty),
		.col_last (col_last),
		.row_last (row_last)
	);

	gvbb_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data (in_data),
		.take    (take),
		.valid_s1(valid_s1),
		.data_s1 (data_s1)
	);

	gvbb_core #(
		.MAX_DIM  (MAX_DIM),
		.COMP_BITS(COMP_BITS),
		.POS_W    (POS_W)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.take     (take),
		.empty    (empty),
		.col_last (col_last),
		.row_last (row_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

// ----- design/gvbb_cfg.sv -----
// Configuration registers: empty value and last column/row of the frame
`default_nettype none
module gvbb_cfg #(
	parameter int MAX_DIM = gvbb_pkg::MAX_DIM_DEF,
	parameter int POS_W   = $clog2(MAX_DIM)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [gvbb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gvbb_pkg::CFG_DATA_W-1:0]   cfg_data,
	output      gvbb_pkg::cell_t                   empty,
	output      logic [POS_W-1:0]                  col_last,
	output      logic [POS_W-1:0]                  row_last
);
	import gvbb_pkg::*;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CW    = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;

	cell_t            empty_q;
	logic [POS_W-1:0] col_last_q;
	logic [POS_W-1:0] row_last_q;

	// Map a size register to its last index: zero acts as one, clamp at MAX_DIM
	function automatic logic [POS_W-1:0] dim_last(input logic [DIM_REG_W-1:0] reg_v);
		logic [CW-1:0] r;
		r = CW'(reg_v);
		if (r == '0)
			return '0;
		if (r > CW'(MAX_DIM))
			return POS_W'(MAX_DIM - 1);
		return POS_W'(r - CW'(1));
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q    <= '0;
			col_last_q <= dim_last(DIM_RESET);
			row_last_q <= dim_last(DIM_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_EMPTY_X:     empty_q.cell_x <= cfg_data;
				CFG_EMPTY_Y:     empty_q.cell_y <= cfg_data;
				CFG_EMPTY_Z:     empty_q.cell_z <= cfg_data;
				CFG_GRID_WIDTH:  col_last_q <= dim_last(cfg_data[DIM_REG_W-1:0]);
				CFG_GRID_HEIGHT: row_last_q <= dim_last(cfg_data[DIM_REG_W-1:0]);
				default: ;
			endcase
		end
	end

	assign empty    = empty_q;
	assign col_last = col_last_q;
	assign row_last = row_last_q;

endmodule
`default_nettype wire

// ----- design/gvbb_in_reg.sv -----
// Input register stage holding one accepted cell
`default_nettype none
module gvbb_in_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_ready,
	input  wire gvbb_pkg::cell_t in_data,
	input  wire logic            take,
	output      logic            valid_s1,
	output      gvbb_pkg::cell_t data_s1
);
	import gvbb_pkg::*;

	logic  v_s1;
	cell_t d_s1;

	// Refill in the same cycle the core drains the stage
	assign in_ready = !v_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			d_s1 <= in_data;
		end
	end

	assign valid_s1 = v_s1;
	assign data_s1  = d_s1;

endmodule
`default_nettype wire

// ----- design/gvbb_core.sv -----
// Scan state, value capture, box update and result register
`default_nettype none
`include "assert_macros.svh"
module gvbb_core #(
	parameter int MAX_DIM   = gvbb_pkg::MAX_DIM_DEF,
	parameter int COMP_BITS = gvbb_pkg::COMP_BITS_DEF,
	parameter int POS_W     = $clog2(MAX_DIM)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire gvbb_pkg::cell_t   data_s1,
	output      logic              take,
	input  wire gvbb_pkg::cell_t   empty,
	input  wire logic [POS_W-1:0]  col_last,
	input  wire logic [POS_W-1:0]  row_last,
	output      logic              out_valid,
	input  wire logic              out_ready,
	output      gvbb_pkg::result_t out_data
);
	import gvbb_pkg::*;

	// Bits above 15 of a sign-extended component only repeat bit 15
	localparam int CMP_W = (COMP_BITS < COMP_W) ? COMP_BITS : COMP_W;

	cell_t            held_q;
	logic             holding_q;
	logic             second_q;
	logic [POS_W-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
	logic [POS_W-1:0] col_q, row_q;

	logic             out_valid_q;
	result_t          res_q;

	logic             is_empty, is_held, capture, match, last, found;
	logic [POS_W-1:0] n_min_col, n_max_col, n_min_row, n_max_row;
	cell_t            n_held;
	result_t          res;

	assign take = valid_s1 && (!out_valid_q || out_ready);

	always_comb begin
		is_empty = (data_s1.cell_x[CMP_W-1:0] == empty.cell_x[CMP_W-1:0]) &&
			(data_s1.cell_y[CMP_W-1:0] == empty.cell_y[CMP_W-1:0]) &&
			(data_s1.cell_z[CMP_W-1:0] == empty.cell_z[CMP_W-1:0]);
		is_held = (data_s1.cell_x[CMP_W-1:0] == held_q.cell_x[CMP_W-1:0]) &&
			(data_s1.cell_y[CMP_W-1:0] == held_q.cell_y[CMP_W-1:0]) &&
			(data_s1.cell_z[CMP_W-1:0] == held_q.cell_z[CMP_W-1:0]);
		capture = !holding_q && !is_empty;
		match   = holding_q && is_held;
		last    = (row_q >= row_last) && (col_q >= col_last);

		n_held    = capture ? data_s1 : held_q;
		n_min_col = min_col_q;
		n_max_col = max_col_q;
		n_min_row = min_row_q;
		n_max_row = max_row_q;
		if (capture) begin
			n_min_col = col_q;
			n_max_col = col_q;
			n_min_row = row_q;
			n_max_row = row_q;
		end else if (match) begin
			if (col_q < min_col_q) n_min_col = col_q;
			if (col_q > max_col_q) n_max_col = col_q;
			if (row_q < min_row_q) n_min_row = row_q;
			if (row_q > max_row_q) n_max_row = row_q;
		end
		found = last && (second_q || match) && (n_max_col != n_min_col) &&
			(n_max_row != n_min_row);

		res            = '0;
		res.consumed   = capture || match;
		res.frame_done = last;
		res.found      = found;
		if (found) begin
			res.left_col   = BOX_W'(n_min_col);
			res.top_row    = BOX_W'(n_min_row);
			res.right_col  = BOX_W'(n_max_col);
			res.bottom_row = BOX_W'(n_max_row);
		end
		if (last) begin
			if (holding_q || capture) begin
				res.picked_x = n_held.cell_x;
				res.picked_y = n_held.cell_y;
				res.picked_z = n_held.cell_z;
			end else begin
				res.picked_x = empty.cell_x;
				res.picked_y = empty.cell_y;
				res.picked_z = empty.cell_z;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			holding_q <= 1'b0;
			second_q  <= 1'b0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (take) begin
			if (last) begin
				// Clear for the next frame
				held_q    <= '0;
				holding_q <= 1'b0;
				second_q  <= 1'b0;
				min_col_q <= '0;
				max_col_q <= '0;
				min_row_q <= '0;
				max_row_q <= '0;
				col_q     <= '0;
				row_q     <= '0;
			end else begin
				held_q    <= n_held;
				holding_q <= holding_q || capture;
				second_q  <= second_q || match;
				min_col_q <= n_min_col;
				max_col_q <= n_max_col;
				min_row_q <= n_min_row;
				max_row_q <= n_max_row;
				if (col_q >= col_last) begin
					col_q <= '0;
					row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	`GVBB_ASSERT_IMP(a_found_on_last, out_valid_q && res_q.found, res_q.frame_done,
		"found reported on a beat that does not end the frame")
	`GVBB_ASSERT_NEXT(a_clear_after_last, take && last,
		!holding_q && !second_q && col_q == '0 && row_q == '0,
		"scan state not cleared after the last cell")
	`GVBB_ASSERT_IMP(a_second_needs_hold, second_q, holding_q,
		"second match recorded without a captured value")
	`GVBB_ASSERT_IMP(a_hold_drop, $fell(holding_q), $past(take && last),
		"captured value dropped before frame end")

endmodule
`default_nettype wire
